// File: design/pom_pkg.sv
// Shared types, constants and tables for the polyphonic oscillator mixer.
`default_nettype none
package pom_pkg;

    typedef enum logic [1:0] {
        CMD_KEY_DOWN = 2'd0,
        CMD_KEY_UP   = 2'd1,
        CMD_TICK     = 2'd2,
        CMD_NONE     = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        WAVE_SINE   = 3'd0,
        WAVE_TRI    = 3'd1,
        WAVE_SAW    = 3'd2,
        WAVE_SQUARE = 3'd3,
        WAVE_NOISE  = 3'd4
    } wave_t;

    localparam logic [2:0] REG_WAVE   = 3'd0;
    localparam logic [2:0] REG_OCTAVE = 3'd1;
    localparam logic [2:0] REG_BASE   = 3'd2;
    localparam logic [2:0] REG_LMAX   = 3'd3;
    localparam logic [2:0] REG_DECAY  = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KEY_RD,
        ST_KEY_WR,
        ST_TICK_RD,
        ST_TICK_MAC,
        ST_TICK_WR,
        ST_OUT
    } state_t;

    localparam logic [20:0] LEVEL_TOP   = 21'h1FFFFF;
    localparam logic [15:0] LFSR_RESET  = 16'hACE1;
    localparam logic [15:0] LFSR_TAPS   = 16'hB400;
    localparam logic [2:0]  CFG_IDX_W   = 3;

    // Semitone ratios, round(2^(s/12) * 65536)
    function automatic logic [16:0] semi_q16(input logic [3:0] s);
        logic [16:0] r;
        begin
            case (s)
                4'd0:    r = 17'd65536;
                4'd1:    r = 17'd69433;
                4'd2:    r = 17'd73562;
                4'd3:    r = 17'd77936;
                4'd4:    r = 17'd82570;
                4'd5:    r = 17'd87480;
                4'd6:    r = 17'd92682;
                4'd7:    r = 17'd98193;
                4'd8:    r = 17'd104032;
                4'd9:    r = 17'd110218;
                4'd10:   r = 17'd116772;
                4'd11:   r = 17'd123715;
                default: r = 17'd65536;
            endcase
            return r;
        end
    endfunction

endpackage
`default_nettype wire

// File: design/pom_sine_rom.sv
// Quarter-wave sine generator: table of sine values built at elaboration.
`default_nettype none
module pom_sine_rom #(
    parameter int DEPTH = 256
) (
    input  wire logic [$clog2(DEPTH)-1:0] idx,
    output logic signed [16:0]            value
);
    localparam int IW = $clog2(DEPTH);

    // Series evaluation matching the fixed-point Taylor form, run at elaboration
    function automatic logic [16:0] sine_mag(input longint u);
        longint unsigned x, x2, t, s, v;
        longint unsigned one;
        begin
            one = 64'd1073741824;
            x   = (64'd1686629713 * 64'(u)) / 64'(DEPTH);
            x2  = (x * x) >> 30;
            t   = one;
            t   = one - ((x2 * t) >> 30) / 110;
            t   = one - ((x2 * t) >> 30) / 72;
            t   = one - ((x2 * t) >> 30) / 42;
            t   = one - ((x2 * t) >> 30) / 20;
            t   = one - ((x2 * t) >> 30) / 6;
            s   = (x * t) >> 30;
            v   = (s * 64'd32768 + (one >> 1)) >> 30;
            if (v > 64'd32768)
                v = 64'd32768;
            return v[16:0];
        end
    endfunction

    logic [16:0] rom [DEPTH/4+1];

    for (genvar g = 0; g <= DEPTH / 4; g++) begin : g_rom
        assign rom[g] = sine_mag(4 * g);
    end

    // Fold the index into the first quarter
    logic [IW+1:0] u;
    logic          neg;
    logic [IW+1:0] uf;
    logic [16:0]   mag;

    always_comb
    begin
        u   = {idx, 2'b00};
        neg = u[IW+1];
        if (neg)
            u = u - (IW+2)'(2 * DEPTH);
        uf = (u > (IW+2)'(DEPTH)) ? (IW+2)'(2 * DEPTH) - u : u;
        mag = rom[uf[IW:2]];
        value = neg ? -$signed(mag) : $signed(mag);
    end
endmodule
`default_nettype wire

// File: design/polyphonic_oscillator_mixer_core.sv
// Top level of the polyphonic oscillator mixer.
// Usage:
//   s_axis: one item per command, tdata = {key_index, cmd}. Key events give
//   no output; a tick (cmd 2) gives one m_axis item with the mixed sample.
//   cfg: write channel (cfg_index, cfg_data), taken only while idle; in that
//   cycle it has priority and s_axis_tready stays low.
//   m_axis: tdata = {active_count, sample}, held until taken.
// Timing: a key event goes through read, write and back to idle. A tick
//   starts with the first memory read, then for each voice does a multiply
//   and a write (the next voice is read during the write), and ends by
//   loading the output register. No new item is taken until the core is idle again.
// Reset: all voices silent, LFSR at 0xACE1, registers at their defaults.
//   The voice memory is cleared by a pass over all voices after reset,
//   during which s_axis_tready is low.
// Stall: while a result waits in the output register the next item is
//   accepted; a second tick waits at its end until the first result goes.
`default_nettype none
module polyphonic_oscillator_mixer_core #(
    parameter int VOICES           = 32,
    parameter int PHASE_BITS       = 24,
    parameter int SINE_TABLE_DEPTH = 256,
    parameter int LEVEL_FRAC_BITS  = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [1:0] cmd, [6:2] key_index
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [22:0] cfg_data,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata    // [15:0] sample, [21:16] active_count
);
    localparam int VW  = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int CW  = $clog2(VOICES + 1);
    localparam int SIW = $clog2(SINE_TABLE_DEPTH);
    localparam int SH  = 15 + LEVEL_FRAC_BITS;

    // Configuration registers
    logic [2:0]        wave_reg;
    logic signed [3:0] octave_reg;
    logic [22:0]       base_reg;
    logic [20:0]       lmax_reg;
    logic [15:0]       decay_reg;

    // Voice memory: {held, level, phase}
    logic [PHASE_BITS+21:0] vmem [VOICES];
    logic [PHASE_BITS+21:0] rd_q;
    logic [PHASE_BITS+21:0] wr_d;
    logic [VW-1:0]          rd_addr, wr_addr;
    logic                   wr_en;

    pom_pkg::state_t state_reg, state_next;
    logic [VW-1:0]   vi_reg, vi_next;
    logic [VW-1:0]   key_reg, key_next;
    logic            cmd_up_reg, cmd_up_next;
    logic            clr_reg;
    logic [VW-1:0]   clr_cnt_reg;
    logic signed [16:0] acc_reg, acc_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [15:0]     lfsr_reg, lfsr_next;
    logic            mv_reg, mv_next;
    logic [23:0]     md_reg, md_next;

    // Multiply stage registers
    logic signed [SH+24:0]  prod_reg;
    logic [PHASE_BITS-1:0]  ph_reg;
    logic [20:0]            lv_reg;
    logic                   hd_reg;
    logic                   act_reg;
    logic [PHASE_BITS-1:0]  incr_reg;

    // Memory, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            vmem[wr_addr] <= wr_d;
        rd_q <= vmem[rd_addr];
    end

    // Config port
    assign cfg_ready = (state_reg == pom_pkg::ST_IDLE) && !clr_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_reg   <= 3'd0;
            octave_reg <= 4'sd0;
            base_reg   <= 23'd167392;
            lmax_reg   <= 21'd1845494;
            decay_reg  <= 16'd461;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                pom_pkg::REG_WAVE:   wave_reg   <= cfg_data[2:0];
                pom_pkg::REG_OCTAVE: octave_reg <= cfg_data[3:0];
                pom_pkg::REG_BASE:   base_reg   <= cfg_data;
                pom_pkg::REG_LMAX:   lmax_reg   <= cfg_data[20:0];
                pom_pkg::REG_DECAY:  decay_reg  <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Fields of the read word
    logic                  r_held;
    logic [20:0]           r_level;
    logic [PHASE_BITS-1:0] r_phase;
    assign r_held  = rd_q[PHASE_BITS+21];
    assign r_level = rd_q[PHASE_BITS+20:PHASE_BITS];
    assign r_phase = rd_q[PHASE_BITS-1:0];

    // Waveform of the voice just read
    logic signed [16:0] sine_val;
    logic signed [16:0] wave_val;
    logic [SIW-1:0]     sidx;
    logic [15:0]        tf;
    logic [15:0]        sf;
    logic [PHASE_BITS-1:0] half;
    assign half = {1'b1, {(PHASE_BITS-1){1'b0}}};
    assign sidx = r_phase[PHASE_BITS-1 -: SIW];

    pom_sine_rom #(.DEPTH(SINE_TABLE_DEPTH)) u_sine (
        .idx   (sidx),
        .value (sine_val)
    );

    // Triangle uses the phase below its top bit; saw is the top 16 bits as signed
    always_comb
    begin
        tf = r_phase[PHASE_BITS-2 -: 16];
        sf = r_phase[PHASE_BITS-1 -: 16];
        case (wave_reg)
            pom_pkg::WAVE_SINE:   wave_val = sine_val;
            pom_pkg::WAVE_TRI:    wave_val = r_phase[PHASE_BITS-1]
                                      ? 17'sd32768 - $signed({1'b0, tf})
                                      : $signed({1'b0, tf}) - 17'sd32768;
            pom_pkg::WAVE_SAW:    wave_val = $signed({sf[15], sf});
            pom_pkg::WAVE_SQUARE: wave_val = (r_phase > half) ? 17'sd32768 : -17'sd32768;
            default:              wave_val = 17'sd0;
        endcase
    end

    // Phase increment for voice vi_reg; octave by reciprocal multiply (exact below 511)
    logic [3:0]            n_semi;
    logic [5:0]            n_oct;
    logic [17:0]           n_q;
    logic [39:0]           incr_p;
    logic [PHASE_BITS-1:0] incr;
    logic [9:0]            n_pos;
    always_comb
    begin
        n_pos  = 10'(vi_reg) + 10'd99 + 10'($signed(octave_reg) * 12);
        n_q    = 18'(n_pos) * 18'd171;
        n_oct  = 6'(n_q >> 11);
        n_semi = 4'(n_pos - 10'(n_oct) * 10'd12);
        incr_p = 40'(base_reg) * 40'(pom_pkg::semi_q16(n_semi));
        if (n_oct >= 6'd24)
            incr = PHASE_BITS'(incr_p << (n_oct - 6'd24));
        else
            incr = PHASE_BITS'(incr_p >> (6'd24 - n_oct));
    end

    // Accumulate with truncation and saturation
    logic signed [SH+26:0] t_sum;
    logic signed [SH+26:0] t_mag;
    logic signed [SH+26:0] t_q;
    always_comb
    begin
        t_sum = ((SH+27)'(acc_reg) <<< SH) + (SH+27)'(prod_reg);
        t_mag = t_sum[SH+26] ? -t_sum : t_sum;
        t_q   = t_mag >>> SH;
        if (t_sum[SH+26])
            t_q = -t_q;
    end

    logic [20:0] decayed;
    logic [21:0] restart;
    assign decayed = (lv_reg > 21'(decay_reg)) ? lv_reg - 21'(decay_reg) : 21'd0;
    assign restart = 22'(lmax_reg) + 22'(decay_reg[15:1]);

    logic s_fire;
    assign s_fire = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        state_next  = state_reg;
        vi_next     = vi_reg;
        key_next    = key_reg;
        cmd_up_next = cmd_up_reg;
        acc_next    = acc_reg;
        cnt_next    = cnt_reg;
        lfsr_next   = lfsr_reg;
        mv_next     = mv_reg && !m_axis_tready;
        md_next     = md_reg;
        rd_addr     = vi_reg;
        wr_addr     = vi_reg;
        wr_en       = 1'b0;
        wr_d        = rd_q;
        s_axis_tready = 1'b0;
        if (clr_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_reg;
            wr_d    = '0;
        end
        unique case (state_reg)
            pom_pkg::ST_IDLE:
            begin
                s_axis_tready = !clr_reg && !cfg_valid;
                if (s_fire)
                begin
                    unique case (s_axis_tdata[1:0])
                        pom_pkg::CMD_KEY_DOWN, pom_pkg::CMD_KEY_UP:
                        begin
                            if (32'(s_axis_tdata[6:2]) < VOICES)
                            begin
                                key_next    = VW'(s_axis_tdata[6:2]);
                                cmd_up_next = s_axis_tdata[0];
                                state_next  = pom_pkg::ST_KEY_RD;
                            end
                        end
                        pom_pkg::CMD_TICK:
                        begin
                            vi_next    = '0;
                            acc_next   = '0;
                            cnt_next   = '0;
                            state_next = pom_pkg::ST_TICK_RD;
                        end
                        default: ;
                    endcase
                end
            end
            pom_pkg::ST_KEY_RD:
            begin
                rd_addr    = key_reg;
                state_next = pom_pkg::ST_KEY_WR;
            end
            pom_pkg::ST_KEY_WR:
            begin
                wr_addr = key_reg;
                if (!cmd_up_reg)
                begin
                    wr_en = 1'b1;
                    wr_d  = {1'b1, r_level, r_phase};
                    if (r_level < lmax_reg)
                        wr_d = {1'b1,
                                restart > 22'(pom_pkg::LEVEL_TOP) ? pom_pkg::LEVEL_TOP
                                                                  : restart[20:0],
                                {PHASE_BITS{1'b0}}};
                end
                else if (r_held)
                begin
                    wr_en = 1'b1;
                    wr_d  = {1'b0,
                             (r_level > 21'(decay_reg)) ? r_level - 21'(decay_reg) : 21'd0,
                             r_phase};
                end
                state_next = pom_pkg::ST_IDLE;
            end
            pom_pkg::ST_TICK_RD:
            begin
                state_next = pom_pkg::ST_TICK_MAC;
            end
            pom_pkg::ST_TICK_MAC:
            begin
                state_next = pom_pkg::ST_TICK_WR;
            end
            pom_pkg::ST_TICK_WR:
            begin
                if (act_reg)
                begin
                    if (cnt_reg != CW'(VOICES))
                        cnt_next = cnt_reg + 1'b1;
                    if (wave_reg != pom_pkg::WAVE_NOISE)
                    begin
                        if (t_q > (SH+27)'(32767))
                            acc_next = 17'sd32767;
                        else if (t_q < -(SH+27)'(32768))
                            acc_next = -17'sd32768;
                        else
                            acc_next = 17'(t_q);
                    end
                    wr_en = 1'b1;
                    wr_d  = {hd_reg, (lv_reg < lmax_reg) ? decayed : lv_reg,
                             ph_reg + incr_reg};
                end
                if (32'(vi_reg) == VOICES - 1)
                    state_next = pom_pkg::ST_OUT;
                else
                begin
                    vi_next    = vi_reg + 1'b1;
                    rd_addr    = vi_reg + 1'b1;
                    state_next = pom_pkg::ST_TICK_MAC;
                end
            end
            pom_pkg::ST_OUT:
            begin
                if (!mv_next)
                begin
                    mv_next = 1'b1;
                    if (wave_reg == pom_pkg::WAVE_NOISE)
                    begin
                        if (cnt_reg != '0)
                        begin
                            lfsr_next = (lfsr_reg >> 1) ^ (lfsr_reg[0] ? pom_pkg::LFSR_TAPS : 16'h0);
                            md_next   = {2'b00, 6'(cnt_reg), lfsr_next};
                        end
                        else
                            md_next = {2'b00, 6'(cnt_reg), 16'h0};
                    end
                    else
                        md_next = {2'b00, 6'(cnt_reg), acc_reg[15:0]};
                    state_next = pom_pkg::ST_IDLE;
                end
            end
            default: state_next = pom_pkg::ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= pom_pkg::ST_IDLE;
            vi_reg      <= '0;
            key_reg     <= '0;
            cmd_up_reg  <= 1'b0;
            acc_reg     <= '0;
            cnt_reg     <= '0;
            lfsr_reg    <= pom_pkg::LFSR_RESET;
            mv_reg      <= 1'b0;
            clr_reg     <= 1'b1;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            vi_reg     <= vi_next;
            key_reg    <= key_next;
            cmd_up_reg <= cmd_up_next;
            acc_reg    <= acc_next;
            cnt_reg    <= cnt_next;
            lfsr_reg   <= lfsr_next;
            mv_reg     <= mv_next;
            if (clr_reg)
            begin
                if (32'(clr_cnt_reg) == VOICES - 1)
                    clr_reg <= 1'b0;
                else
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    // Multiply stage, increment of the voice in flight and output payload
    always_ff @(posedge clk)
    begin
        md_reg   <= md_next;
        prod_reg <= (SH+25)'(wave_val * $signed({1'b0, r_level}));
        ph_reg   <= r_phase;
        lv_reg   <= r_level;
        hd_reg   <= r_held;
        act_reg  <= (r_level != 21'd0);
        incr_reg <= incr;
    end

    assign m_axis_tvalid = mv_reg;
    assign m_axis_tdata  = md_reg;

`ifndef NO_ASSERTIONS
    // Input is never taken during the clearing pass
    a_no_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_reg |-> !s_axis_tready)
        else $error("input accepted during clear");
    // A pending result is not overwritten
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (mv_reg && !m_axis_tready) |=> (mv_reg && $stable(md_reg)))
        else $error("output changed while stalled");
    // Active count never exceeds voice count
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cnt_reg) <= VOICES)
        else $error("active count overflow");
`endif
endmodule
`default_nettype wire
